>>> design/btba_pkg.sv
// ----------------------------------------------------------------------------
// btba_pkg: shared types and constants for the boundary-tag block allocator
// Status codes, request kinds, sequencer states and default parameter values.
// ----------------------------------------------------------------------------
package btba_pkg;

  // Defaults for the top-level parameters
  localparam int NUM_BLOCKS_DEF       = 4096;
  localparam int BLOCK_BYTES_LOG2_DEF = 6;
  localparam int RESERVED_BLOCKS_DEF  = 1;

  localparam int COUNT_W = 13;
  localparam int ADDR_W  = 64;

  typedef enum logic [0:0] {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_NO_SPACE      = 3'd1,
    ST_OUT_OF_HEAP   = 3'd2,
    ST_MISALIGNED    = 3'd3,
    ST_NOT_ALLOCATED = 3'd4,
    ST_NOT_RUN_START = 3'd5,
    ST_CORRUPT       = 3'd6
  } status_t;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_A_CHK,
    S_F_OFF,
    S_F_CHK,
    S_F_E,
    S_F_END,
    S_F_PREV,
    S_F_NEXT,
    S_WR,
    S_DONE
  } state_t;

endpackage

>>> design/btba_if.sv
// ----------------------------------------------------------------------------
// btba channel interfaces
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface btba_req_if;
  logic        valid;
  logic        ready;
  logic [0:0]  kind;
  logic [12:0] block_count;
  logic [63:0] address;

  modport source (output valid, kind, block_count, address, input ready);
  modport sink   (input valid, kind, block_count, address, output ready);
endinterface

interface btba_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [63:0] alloc_address;

  modport source (output valid, status, alloc_address, input ready);
  modport sink   (input valid, status, alloc_address, output ready);
endinterface

>>> design/boundary_tag_block_allocator.sv
// ----------------------------------------------------------------------------
// boundary_tag_block_allocator: first-fit block allocator with boundary tags
// Keeps one signed run tag per heap block in an on-chip memory and serves
// allocate and free requests with a small sequencer around one read port.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one request item (kind, block_count, address); rsp returns
//   one item (status, alloc_address) per request. cfg_we/cfg_wdata write
//   heap_base; the user must write it only while the block is idle, as
//   the block itself does not enforce this.
// Operation:
//   One request at a time; req.ready is low while an item is in work.
//   Allocate: one memory read per run (registered read data); on success
//   the tags are written, four on a split and two on an exact fit. A zero
//   count skips the walk. Free: offset and range checks, reads of the
//   run's start, end and neighbor tags, then the tag writes; a rejected
//   free answers without writes. The next item can be taken in the cycle
//   after the result is loaded.
// Reset:
//   rst clears control state and heap_base. A clearing pass then writes the
//   initial tags (reserved run, one free run) over all NUM_BLOCKS entries,
//   one per cycle, so req.ready stays low until the pass is done.
// Stall:
//   The result sits in an output register; a new request can be accepted
//   while it waits. A finished item holds in the sequencer until the
//   output register is free.
// ----------------------------------------------------------------------------
module boundary_tag_block_allocator #(
  parameter int NUM_BLOCKS       = btba_pkg::NUM_BLOCKS_DEF,
  parameter int BLOCK_BYTES_LOG2 = btba_pkg::BLOCK_BYTES_LOG2_DEF,
  parameter int RESERVED_BLOCKS  = btba_pkg::RESERVED_BLOCKS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [btba_pkg::ADDR_W-1:0] cfg_wdata,
  btba_req_if.sink               req,
  btba_rsp_if.source             rsp
);
  import btba_pkg::*;

  localparam int AW    = $clog2(NUM_BLOCKS);
  localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
  localparam int CW    = CNT_W + 1;
  localparam int EW    = CNT_W + 1;
  localparam int XW    = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
  localparam int RES_EFF = (RESERVED_BLOCKS >= NUM_BLOCKS) ? NUM_BLOCKS - 1
                                                            : RESERVED_BLOCKS;
  localparam logic [ADDR_W-1:0] OFF_MASK = (ADDR_W'(1) << BLOCK_BYTES_LOG2) - ADDR_W'(1);

  // Tag memory
  logic signed [EW-1:0] mem [NUM_BLOCKS];
  logic signed [EW-1:0] rd_data;
  logic [AW-1:0]        rd_addr;
  logic                 we;
  logic [AW-1:0]        waddr;
  logic signed [EW-1:0] wdata;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data <= mem[rd_addr];
  end

  // Control and working registers
  state_t state, state_next;
  logic [ADDR_W-1:0]  heap_base;
  logic [AW-1:0]      clr;
  kind_t              kind;
  logic [COUNT_W-1:0] cnt;
  logic [ADDR_W-1:0]  addr_in;
  logic [ADDR_W-1:0]  off;
  logic               borrow;
  logic [CNT_W-1:0]   i;
  logic [CNT_W-1:0]   len;
  logic               split;
  logic [CNT_W-1:0]   k;
  logic [CNT_W-1:0]   size;
  logic [CNT_W-1:0]   plen;
  logic [CNT_W-1:0]   nlen;
  logic               merge_lo;
  logic               merge_hi;
  logic [2:0]         wstep;
  status_t            st;
  logic               rsp_valid;
  status_t            rsp_status;
  logic [ADDR_W-1:0]  rsp_addr;

  // Decode of the tag just read
  logic                 e_neg, e_zero;
  logic [EW-1:0]        e_mag;
  logic [CNT_W-1:0]     len_abs;
  logic [CW-1:0]        i_sum, i_room, k_room, ks_sum, ks_room;
  logic                 a_corrupt, a_split, a_exact, a_end;
  logic [ADDR_W-1:0]    blk;
  logic                 req_acc, out_free, wr_last;

  assign e_neg   = rd_data[EW-1];
  assign e_zero  = (rd_data == '0);
  assign e_mag   = e_neg ? (~rd_data + 1'b1) : rd_data;
  assign len_abs = e_mag[CNT_W-1:0];
  assign i_sum   = {1'b0, i} + {1'b0, len_abs};
  assign i_room  = CW'(NUM_BLOCKS) - {1'b0, i};
  assign k_room  = CW'(NUM_BLOCKS) - {1'b0, k};
  assign ks_sum  = {1'b0, k} + {1'b0, size};
  assign ks_room = CW'(NUM_BLOCKS) - ks_sum;
  assign a_corrupt = e_zero || ({1'b0, len_abs} > i_room);
  assign a_split   = e_neg && (XW'(len_abs) > XW'(cnt));
  assign a_exact   = e_neg && (XW'(len_abs) == XW'(cnt));
  assign a_end     = (i_sum >= CW'(NUM_BLOCKS));
  assign blk       = off >> BLOCK_BYTES_LOG2;
  assign req_acc   = req.valid && req.ready;
  assign out_free  = !rsp_valid || rsp.ready;
  assign wr_last   = (kind == KIND_FREE) ? (wstep == 3'd5) : (wstep == 3'd3);

  assign req.ready         = (state == S_IDLE);
  assign rsp.valid         = rsp_valid;
  assign rsp.status        = rsp_status;
  assign rsp.alloc_address = rsp_addr;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLR:   if (clr == AW'(NUM_BLOCKS - 1)) state_next = S_IDLE;
      S_IDLE: begin
        if (req_acc) begin
          if (req.kind == KIND_FREE)   state_next = S_F_OFF;
          else if (req.block_count == '0) state_next = S_DONE;
          else                         state_next = S_A_CHK;
        end
      end
      S_A_CHK: begin
        if (a_corrupt)                  state_next = S_DONE;
        else if (a_split || a_exact)    state_next = S_WR;
        else if (a_end)                 state_next = S_DONE;
      end
      S_F_OFF: state_next = S_F_CHK;
      S_F_CHK: begin
        if (borrow || blk >= ADDR_W'(NUM_BLOCKS) || (off & OFF_MASK) != '0)
          state_next = S_DONE;
        else
          state_next = S_F_E;
      end
      S_F_E: begin
        if (e_neg || e_zero || {1'b0, len_abs} > k_room) state_next = S_DONE;
        else                                             state_next = S_F_END;
      end
      S_F_END: begin
        if (rd_data != EW'(size))              state_next = S_DONE;
        else if (k != '0)                      state_next = S_F_PREV;
        else if (ks_sum < CW'(NUM_BLOCKS))     state_next = S_F_NEXT;
        else                                   state_next = S_WR;
      end
      S_F_PREV: begin
        if (e_neg && (len_abs > k))            state_next = S_DONE;
        else if (ks_sum < CW'(NUM_BLOCKS))     state_next = S_F_NEXT;
        else                                   state_next = S_WR;
      end
      S_F_NEXT: begin
        if (e_neg && ({1'b0, len_abs} > ks_room)) state_next = S_DONE;
        else                                      state_next = S_WR;
      end
      S_WR:    if (wr_last) state_next = S_DONE;
      S_DONE:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Memory address and write selection
  logic [CW-1:0]        start, total;
  logic signed [EW-1:0] rest;

  assign start = merge_lo ? ({1'b0, k} - {1'b0, plen}) : {1'b0, k};
  assign total = {1'b0, size} + (merge_lo ? {1'b0, plen} : '0)
               + (merge_hi ? {1'b0, nlen} : '0);
  // negative length of the free remainder after a split
  assign rest  = EW'(cnt) - EW'(len);

  always_comb begin
    rd_addr = '0;
    we      = 1'b0;
    waddr   = '0;
    wdata   = '0;
    case (state)
      S_CLR: begin
        we    = 1'b1;
        waddr = clr;
        if (clr == '0 || clr == AW'(RES_EFF - 1))
          wdata = EW'(RES_EFF);
        else if (clr == AW'(RES_EFF) || clr == AW'(NUM_BLOCKS - 1))
          wdata = EW'(RES_EFF - NUM_BLOCKS);
      end
      S_IDLE:  rd_addr = '0;
      S_A_CHK: rd_addr = i_sum[AW-1:0];
      S_F_CHK: rd_addr = blk[AW-1:0];
      S_F_E: begin
        rd_addr = AW'(k + len_abs - 1'b1);
      end
      S_F_END: begin
        if (k != '0) rd_addr = AW'(k - 1'b1);
        else         rd_addr = ks_sum[AW-1:0];
      end
      S_F_PREV: rd_addr = ks_sum[AW-1:0];
      S_WR: begin
        if (kind == KIND_ALLOC) begin
          case (wstep)
            3'd0: begin we = split; waddr = AW'(i + len - 1'b1); wdata = rest; end
            3'd1: begin we = split; waddr = AW'(XW'(i) + XW'(cnt)); wdata = rest; end
            3'd2: begin
              we = 1'b1; waddr = AW'(XW'(i) + XW'(cnt) - 1'b1); wdata = EW'(cnt);
            end
            default: begin we = 1'b1; waddr = i[AW-1:0]; wdata = EW'(cnt); end
          endcase
        end else begin
          case (wstep)
            3'd0: begin we = merge_lo; waddr = AW'(k - 1'b1); end
            3'd1: begin we = merge_lo; waddr = k[AW-1:0]; end
            3'd2: begin we = merge_hi; waddr = AW'(ks_sum - 1'b1); end
            3'd3: begin we = merge_hi; waddr = ks_sum[AW-1:0]; end
            3'd4: begin we = 1'b1; waddr = start[AW-1:0]; wdata = EW'(-total); end
            default: begin
              we = 1'b1; waddr = AW'(start + total - 1'b1); wdata = EW'(-total);
            end
          endcase
        end
      end
      default: rd_addr = '0;
    endcase
  end

  // Registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr       <= '0;
      heap_base <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) heap_base <= cfg_wdata;
      if (state == S_DONE && out_free) rsp_valid <= 1'b1;
      else if (rsp.ready)              rsp_valid <= 1'b0;
      case (state)
        S_CLR: clr <= clr + 1'b1;
        S_IDLE: begin
          if (req_acc) begin
            kind      <= kind_t'(req.kind);
            cnt       <= req.block_count;
            addr_in   <= req.address;
            i         <= '0;
            merge_lo  <= 1'b0;
            merge_hi  <= 1'b0;
            wstep     <= '0;
            st        <= ST_NO_SPACE;
          end
        end
        S_A_CHK: begin
          if (a_corrupt) st <= ST_CORRUPT;
          else if (a_split || a_exact) begin
            split <= a_split;
            len   <= len_abs;
            st    <= ST_OK;
          end else begin
            i <= i_sum[CNT_W-1:0];
          end
        end
        S_F_OFF: {borrow, off} <= {1'b0, addr_in} - {1'b0, heap_base};
        S_F_CHK: begin
          k <= blk[CNT_W-1:0];
          if (borrow || blk >= ADDR_W'(NUM_BLOCKS)) st <= ST_OUT_OF_HEAP;
          else                                     st <= ST_MISALIGNED;
        end
        S_F_E: begin
          size <= len_abs;
          if (e_neg || e_zero) st <= ST_NOT_ALLOCATED;
          else                 st <= ST_CORRUPT;
        end
        S_F_END: st <= ST_NOT_RUN_START;
        S_F_PREV: begin
          st <= ST_CORRUPT;
          if (e_neg) begin
            merge_lo <= 1'b1;
            plen     <= len_abs;
          end
        end
        S_F_NEXT: begin
          st <= ST_CORRUPT;
          if (e_neg) begin
            merge_hi <= 1'b1;
            nlen     <= len_abs;
          end
        end
        S_WR: begin
          wstep <= wstep + 1'b1;
          st    <= ST_OK;
        end
        S_DONE: begin
          if (out_free) begin
            rsp_status <= st;
            rsp_addr   <= (kind == KIND_ALLOC && st == ST_OK)
                        ? heap_base + (ADDR_W'(i) << BLOCK_BYTES_LOG2) : '0;
          end
        end
        default: clr <= clr;
      endcase
    end
  end

  // Checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_acc |=> !req.ready) else $error("ready high right after accept");
  a_clr_not_ready: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLR) |-> !req.ready) else $error("ready during clearing pass");
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_status != 3'd7)) else $error("bad status code");
  a_fail_zero_addr: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_status != ST_OK) |-> (rsp_addr == '0))
    else $error("address on failed request");
  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !we) else $error("tag write while idle");

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the boundary-tag block allocator
// Drives allocate and free requests, tracks the run tags in a local model,
// and compares every response item against the predicted status and address.
// ----------------------------------------------------------------------------
module tb_top;
  import btba_pkg::*;

  localparam int NB   = NUM_BLOCKS_DEF;
  localparam int BLG  = BLOCK_BYTES_LOG2_DEF;
  localparam int RSV  = RESERVED_BLOCKS_DEF;
  localparam int WDOG = 40000;

  typedef struct packed {
    kind_t       kind;
    logic [12:0] block_count;
    logic [63:0] address;
  } request_t;

  typedef struct packed {
    status_t     status;
    logic [63:0] alloc_address;
  } response_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [63:0] cfg_wdata = '0;

  btba_req_if req ();
  btba_rsp_if rsp ();

  boundary_tag_block_allocator u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .req(req.sink), .rsp(rsp.source)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Local copy of the tag array and heap base
  int          tags [NB];
  logic [63:0] base_addr;
  logic [63:0] live_addrs [$];

  request_t  pending_reqs [$];
  response_t expected_rsps [$];
  int  errors = 0;
  int  n_rsp = 0;
  int  n_ok_alloc = 0;
  int  wdog = 0;
  bit  calm = 1'b0;
  int  hold_off = 0;
  bit  stim_done = 1'b0;

  function automatic void reset_tags();
    int r;
    r = (RSV >= NB) ? NB - 1 : RSV;
    foreach (tags[i]) tags[i] = 0;
    tags[0] = r;
    tags[r - 1] = r;
    tags[r] = -(NB - r);
    tags[NB - 1] = -(NB - r);
  endfunction

  function automatic response_t alloc_run(int cnt);
    response_t res;
    int i, e, len;
    res = '{ST_NO_SPACE, 64'd0};
    if (cnt == 0) return res;
    i = 0;
    while (i < NB) begin
      e = tags[i];
      if (e == 0) return '{ST_CORRUPT, 64'd0};
      len = (e > 0) ? e : -e;
      if (len > NB - i) return '{ST_CORRUPT, 64'd0};
      if (e < 0 && len >= cnt) begin
        if (len > cnt) begin
          tags[i + len - 1] = -(len - cnt);
          tags[i + cnt] = -(len - cnt);
        end
        tags[i + cnt - 1] = cnt;
        tags[i] = cnt;
        return '{ST_OK, base_addr + (64'(i) << BLG)};
      end
      i += len;
    end
    return res;
  endfunction

  function automatic status_t free_run(logic [63:0] a);
    logic [63:0] off, blk;
    int k, sz, plen, nlen, start, total;
    bit pf, nf;
    pf = 0; nf = 0; plen = 0; nlen = 0;
    if (a < base_addr) return ST_OUT_OF_HEAP;
    off = a - base_addr;
    blk = off >> BLG;
    if (blk >= 64'(NB)) return ST_OUT_OF_HEAP;
    if ((off & ((64'd1 << BLG) - 1)) != 0) return ST_MISALIGNED;
    k = int'(blk);
    if (tags[k] <= 0) return ST_NOT_ALLOCATED;
    sz = tags[k];
    if (sz > NB - k) return ST_CORRUPT;
    if (tags[k + sz - 1] != sz) return ST_NOT_RUN_START;
    if (k > 0 && tags[k - 1] < 0) begin
      plen = -tags[k - 1];
      if (plen > k) return ST_CORRUPT;
      pf = 1;
    end
    if (k + sz < NB && tags[k + sz] < 0) begin
      nlen = -tags[k + sz];
      if (nlen > NB - (k + sz)) return ST_CORRUPT;
      nf = 1;
    end
    start = k;
    total = sz;
    if (pf) begin
      tags[k - 1] = 0;
      tags[k] = 0;
      start = k - plen;
      total += plen;
    end
    if (nf) begin
      tags[k + sz - 1] = 0;
      tags[k + sz] = 0;
      total += nlen;
    end
    tags[start] = -total;
    tags[start + total - 1] = -total;
    return ST_OK;
  endfunction

  function automatic response_t predict_response(request_t r);
    response_t res;
    if (r.kind == KIND_ALLOC) begin
      res = alloc_run(int'(r.block_count));
    end else begin
      res.status = free_run(r.address);
      res.alloc_address = 64'd0;
    end
    return res;
  endfunction

  // Request driver; the item on the bus stays at the queue front until accepted
  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else if (!req.valid || req.ready) begin
      if (req.valid && req.ready) void'(pending_reqs.pop_front());
      if (pending_reqs.size() > 0 && (calm || $urandom_range(99) >= 16)) begin
        request_t nx;
        nx = pending_reqs[0];
        req.valid <= 1'b1;
        req.kind <= nx.kind;
        req.block_count <= nx.block_count;
        req.address <= nx.address;
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  // Predict at acceptance
  always @(posedge clk) begin
    if (!rst && req.valid && req.ready) begin
      request_t r;
      response_t p;
      r = '{kind_t'(req.kind), req.block_count, req.address};
      p = predict_response(r);
      if (r.kind == KIND_ALLOC && p.status == ST_OK) live_addrs.push_back(p.alloc_address);
      expected_rsps.push_back(p);
    end
  end

  // Response monitor and sink stalls
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        response_t exp_r;
        n_rsp++;
        if (expected_rsps.size() == 0) begin
          $display("%0t: unexpected response status=%0d addr=%h", $time,
                   rsp.status, rsp.alloc_address);
          errors++;
        end else begin
          exp_r = expected_rsps.pop_front();
          if (rsp.status !== exp_r.status)
            begin
              $display("%0t: status mismatch expected %0d actual %0d", $time,
                       exp_r.status, rsp.status);
              errors++;
            end
          if (rsp.alloc_address !== exp_r.alloc_address) begin
            $display("%0t: address mismatch expected %h actual %h", $time,
                     exp_r.alloc_address, rsp.alloc_address);
            errors++;
          end
          if (exp_r.status == ST_OK && exp_r.alloc_address != 0) n_ok_alloc++;
        end
      end
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= calm || ($urandom_range(99) >= 16);
      end
    end
  end

  // Watchdog on cycles with no accepted item
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      wdog <= 0;
    end else if (!stim_done || expected_rsps.size() != 0) begin
      wdog <= wdog + 1;
      if (wdog >= WDOG) begin
        $display("watchdog expired, %0d responses outstanding", expected_rsps.size());
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic push_alloc(int cnt);
    pending_reqs.push_back('{KIND_ALLOC, 13'(cnt), 64'(0)});
  endtask

  task automatic push_free(logic [63:0] a);
    pending_reqs.push_back('{KIND_FREE, 13'(0), a});
  endtask

  // Wait until the allocator is drained and idle
  task automatic drain();
    while (pending_reqs.size() != 0 || req.valid || expected_rsps.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_base(logic [63:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    base_addr = v;
    live_addrs.delete();
  endtask

  // Random traffic: mostly valid frees of live runs and small allocations
  task automatic random_phase(int n);
    int sel;
    logic [63:0] a;
    for (int j = 0; j < n; j++) begin
      sel = $urandom_range(99);
      if (sel < 40) begin
        push_alloc(($urandom_range(9) == 0) ? $urandom_range(8191) : $urandom_range(1, 24));
      end else if (sel < 80 && live_addrs.size() > 0) begin
        int idx;
        idx = $urandom_range(live_addrs.size() - 1);
        push_free(live_addrs[idx]);
        live_addrs.delete(idx);
      end else if (sel < 90) begin
        a = base_addr + (64'($urandom_range(NB - 1)) << BLG);
        push_free(a);
      end else begin
        a = {$urandom, $urandom};
        push_free(a);
      end
      // live list is rebuilt as predictions land; sync occasionally
      if (pending_reqs.size() > 8) wait (pending_reqs.size() <= 2);
    end
  endtask

  initial begin
    logic [63:0] top_addr;
    req.valid = 1'b0;
    req.kind = KIND_ALLOC;
    req.block_count = '0;
    req.address = '0;
    rsp.ready = 1'b0;
    reset_tags();
    base_addr = 64'd0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: field extremes, special cases, reserved run
    push_alloc(0);
    push_alloc(8191);
    push_alloc(4096);
    push_alloc(NB - RSV);
    push_alloc(1);
    push_free(64'd0);
    push_free(64'd0);
    push_alloc(NB);
    push_free(64'd64);
    push_alloc(3);
    push_alloc(2);
    push_free(64'd64 + 64'd64);
    push_free(64'd65);
    push_free(64'(NB) << BLG);
    push_free(64'hFFFF_FFFF_FFFF_FFFF);
    push_free(64'd64);
    push_free(64'd256);
    push_alloc(5);
    drain();

    // Nonzero base near the top of the address space
    top_addr = 64'hFFFF_FFFF_FFFF_0000;
    write_base(top_addr);
    push_free(64'd0);
    push_free(top_addr - 1);
    push_alloc(4);
    push_alloc(4);
    drain();
    live_addrs.delete();
    // Predicted live runs are recovered from the tag array for random frees
    foreach (tags[i]) if (tags[i] > 0 && (i == 0 || tags[i - 1] != tags[i] || tags[i] == 1))
      live_addrs.push_back(base_addr + (64'(i) << BLG));

    // Long receiver stall while the sender keeps offering items
    hold_off = 400;
    random_phase(20);
    drain();

    // Calm stretch with no idling
    calm = 1'b1;
    random_phase(150);
    drain();
    calm = 1'b0;

    write_base({$urandom, $urandom} & ~64'h3F);
    random_phase(300);
    drain();

    write_base(64'h5555_AAAA_0000_1000);
    random_phase(300);
    drain();

    write_base(64'd0);
    random_phase(230);
    drain();

    stim_done = 1'b1;
    $display("covered %0d responses, %0d successful allocations, heap base changes incl. extremes",
             n_rsp, n_ok_alloc);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

>>> sim.f
design/btba_pkg.sv
design/btba_if.sv
design/boundary_tag_block_allocator.sv
tb/tb_top.sv
